@@ design/ecd_pkg.sv @@
// Shared types, constants and helper functions for the epoch seconds to civil date block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ecd_pkg;

    // Offset that makes any 36-bit signed second count non-negative.
    // It is a whole number of days: 397683 days of 86400 seconds.
    localparam logic [36:0] C_SECS_OFFSET = 37'd34359811200;

    // Unsigned day count plus this gives days since 1 January of year 0.
    localparam logic [20:0] C_YEAR0_SHIFT = 21'd321845;

    // Unsigned day count plus this is congruent to the weekday modulo 7.
    localparam logic [19:0] C_WEEKDAY_SHIFT = 20'd5;

    // Divisor of the day split once the seconds have lost seven low bits.
    localparam logic [9:0]  C_DAY_DIV       = 10'd675;
    localparam logic [29:0] C_RECIP_675     = 30'd814453057;
    localparam int          C_SHIFT_675     = 39;

    // Exact reciprocals for the smaller divisions.
    localparam logic [12:0] C_RECIP_225     = 13'd4661;
    localparam int          C_SHIFT_225     = 20;
    localparam logic [10:0] C_RECIP_15      = 11'd1093;
    localparam int          C_SHIFT_15      = 14;
    localparam logic [20:0] C_RECIP_365     = 21'd1470880;
    localparam int          C_SHIFT_365     = 29;
    localparam logic [20:0] C_RECIP_7       = 21'd1198373;
    localparam int          C_SHIFT_7       = 23;
    localparam logic [12:0] C_RECIP_100     = 13'd5243;
    localparam int          C_SHIFT_100     = 19;

    localparam logic [11:0] C_SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  C_SECS_PER_MIN   = 6'd60;
    localparam logic [2:0]  C_DAYS_PER_WEEK  = 3'd7;
    localparam logic [8:0]  C_DAYS_PER_YEAR  = 9'd365;
    localparam logic [6:0]  C_YEARS_PER_CENT = 7'd100;
    localparam logic [11:0] C_YEAR_BASE      = 12'd1900;

    // Word leaving the day split: day count and second within the day.
    typedef struct packed {
        logic        valid;
        logic [19:0] day_count;
        logic [16:0] sec_of_day;
    } t_split;

    // Word leaving the calendar pipeline, with the full year.
    typedef struct packed {
        logic        valid;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
    } t_civil;

    // Gregorian leap rule from the year modulo 4, the year modulo 100 and
    // the number of whole centuries.
    function automatic logic f_is_leap(input logic [1:0] y_mod4,
                                       input logic [6:0] y_mod100,
                                       input logic [4:0] centuries);
        logic leap;
        if (y_mod100 == 7'd0) begin
            leap = (centuries[1:0] == 2'd0);
        end else begin
            leap = (y_mod4 == 2'd0);
        end
        return leap;
    endfunction

    // Day of year on which each month starts.
    function automatic logic [8:0] f_month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] start_day;
        unique case (idx)
            4'd0:    start_day = 9'd0;
            4'd1:    start_day = 9'd31;
            4'd2:    start_day = leap ? 9'd60  : 9'd59;
            4'd3:    start_day = leap ? 9'd91  : 9'd90;
            4'd4:    start_day = leap ? 9'd121 : 9'd120;
            4'd5:    start_day = leap ? 9'd152 : 9'd151;
            4'd6:    start_day = leap ? 9'd182 : 9'd181;
            4'd7:    start_day = leap ? 9'd213 : 9'd212;
            4'd8:    start_day = leap ? 9'd244 : 9'd243;
            4'd9:    start_day = leap ? 9'd274 : 9'd273;
            4'd10:   start_day = leap ? 9'd305 : 9'd304;
            4'd11:   start_day = leap ? 9'd335 : 9'd334;
            default: start_day = 9'd0;
        endcase
        return start_day;
    endfunction

endpackage

`default_nettype wire

@@ design/ecd_day_split.sv @@
// Splits an offset second count into an unsigned day count and a second of the day.
// Depends on ecd_pkg for the reciprocal constants and the t_split word.
`default_nettype none

module ecd_day_split
    import ecd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [36:0] i_secs,
    output t_split           o_split
);

    logic        r_v2, r_v3, r_v4;
    logic [29:0] r_x2;
    logic [6:0]  r_lo2, r_lo3, r_lo4;
    logic [59:0] r_prod2, n_prod2;
    logic [20:0] r_q3, w_q3;
    logic [10:0] r_rem3, n_rem3;
    logic [30:0] w_qd3;
    logic [19:0] r_day4, n_day4;
    logic [9:0]  r_rem4, n_rem4;
    logic        w_fix4;

    // Stage two: seconds over 128 times the reciprocal of 675.
    assign n_prod2 = 60'(i_secs[36:7]) * 60'(C_RECIP_675);

    // Stage three: estimated quotient, at most one short, and its remainder.
    assign w_q3   = r_prod2[59:C_SHIFT_675];
    assign w_qd3  = 31'(w_q3) * 31'(C_DAY_DIV);
    assign n_rem3 = 11'(31'(r_x2) - w_qd3);

    // Stage four: one correction step brings the remainder below 675.
    assign w_fix4 = (r_rem3 >= 11'(C_DAY_DIV));
    assign n_day4 = 20'(r_q3 + 21'(w_fix4));
    assign n_rem4 = w_fix4 ? 10'(r_rem3 - 11'(C_DAY_DIV)) : r_rem3[9:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x2    <= i_secs[36:7];
        r_lo2   <= i_secs[6:0];
        r_prod2 <= n_prod2;
        r_q3    <= w_q3;
        r_rem3  <= n_rem3;
        r_lo3   <= r_lo2;
        r_day4  <= n_day4;
        r_rem4  <= n_rem4;
        r_lo4   <= r_lo3;
    end

    // The second of the day is the remainder rejoined with the low bits.
    assign o_split.valid      = r_v4;
    assign o_split.day_count  = r_day4;
    assign o_split.sec_of_day = {r_rem4, r_lo4};

    // The estimated quotient is never more than one short.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_rem3 < 11'd1350))
        else $error("day split remainder out of range");

    // The corrected remainder always gives a second inside the day.
    a_sec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_rem4 < 10'(C_DAY_DIV)))
        else $error("second of day out of range");

endmodule

`default_nettype wire

@@ design/ecd_fields.sv @@
// Calendar pipeline: time of day, weekday, year search and month search.
// Depends on ecd_pkg for constants, functions and the t_split and t_civil words.
`default_nettype none

module ecd_fields
    import ecd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_split    i_split,
    output t_civil    o_civil
);

    logic r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11;

    // Stage five: the three reciprocal products.
    logic [20:0] n_d5, r_d5;
    logic [19:0] n_wx5, r_wx5;
    logic [16:0] r_sec5;
    logic [25:0] n_hprod5, r_hprod5;
    logic [41:0] n_yprod5, r_yprod5;
    logic [40:0] n_wprod5, r_wprod5;

    assign n_d5     = 21'(i_split.day_count) + C_YEAR0_SHIFT;
    assign n_wx5    = i_split.day_count + C_WEEKDAY_SHIFT;
    assign n_hprod5 = 26'(i_split.sec_of_day[16:4]) * 26'(C_RECIP_225);
    assign n_yprod5 = 42'(n_d5) * 42'(C_RECIP_365);
    assign n_wprod5 = 41'(n_wx5) * 41'(C_RECIP_7);

    // Stage six: hour, second of the hour, year estimate, weekday.
    logic [4:0]  w_hour6, r_hour6;
    logic [16:0] w_hs6;
    logic [11:0] n_rem6, r_rem6;
    logic [11:0] w_y6, r_y6;
    logic [17:0] w_wq6;
    logic [19:0] w_w7;
    logic [2:0]  n_wd6, r_wd6;
    logic [20:0] r_d6;

    assign w_hour6 = r_hprod5[C_SHIFT_225 + 4:C_SHIFT_225];
    assign w_hs6   = 17'(w_hour6) * 17'(C_SECS_PER_HOUR);
    assign n_rem6  = 12'(r_sec5 - w_hs6);
    assign w_y6    = r_yprod5[C_SHIFT_365 + 11:C_SHIFT_365];
    assign w_wq6   = r_wprod5[40:C_SHIFT_7];
    assign w_w7    = 20'(w_wq6) * 20'(C_DAYS_PER_WEEK);
    assign n_wd6   = 3'(r_wx5 - w_w7);

    // Stage seven: minute product and century product.
    logic [19:0] n_mprod7, r_mprod7;
    logic [23:0] n_qprod7, r_qprod7;
    logic [11:0] r_rem7, r_y7;
    logic [4:0]  r_hour7;
    logic [2:0]  r_wd7;
    logic [20:0] r_d7;

    assign n_mprod7 = 20'(r_rem6[11:2]) * 20'(C_RECIP_15);
    assign n_qprod7 = 24'(r_y6) * 24'(C_RECIP_100);

    // Stage eight: minute, second, centuries and year within the century.
    logic [5:0]  w_min8, r_min8, n_sec8, r_sec8;
    logic [11:0] w_ms8, w_cy8;
    logic [4:0]  w_q100_8, r_q100_8;
    logic [6:0]  n_r100_8, r_r100_8;
    logic [11:0] r_y8;
    logic [4:0]  r_hour8;
    logic [2:0]  r_wd8;
    logic [20:0] r_d8;

    assign w_min8   = r_mprod7[C_SHIFT_15 + 5:C_SHIFT_15];
    assign w_ms8    = 12'(w_min8) * 12'(C_SECS_PER_MIN);
    assign n_sec8   = 6'(r_rem7 - w_ms8);
    assign w_q100_8 = r_qprod7[C_SHIFT_100 + 4:C_SHIFT_100];
    assign w_cy8    = 12'(w_q100_8) * 12'(C_YEARS_PER_CENT);
    assign n_r100_8 = 7'(r_y7 - w_cy8);

    // Stage nine: first day of the estimated year, and the leap flags of
    // the estimate and of the three years below it.
    logic [6:0]  w_rk9 [4];
    logic [4:0]  w_qk9 [4];
    logic [3:0]  w_leap9, r_leap9;
    logic [20:0] n_f9, r_f9;
    logic [11:0] r_y9;
    logic [20:0] r_d9;
    logic [5:0]  r_min9, r_sec9;
    logic [4:0]  r_hour9;
    logic [2:0]  r_wd9;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_r100_8 >= 7'(k)) begin
                w_rk9[k] = r_r100_8 - 7'(k);
                w_qk9[k] = r_q100_8;
            end else begin
                w_rk9[k] = 7'(r_r100_8 + C_YEARS_PER_CENT - 7'(k));
                w_qk9[k] = r_q100_8 - 5'd1;
            end
            w_leap9[k] = f_is_leap(r_y8[1:0] - 2'(k), w_rk9[k], w_qk9[k]);
        end
    end

    assign n_f9 = 21'(r_y8) * 21'(C_DAYS_PER_YEAR) + 21'(r_y8[11:2]) - 21'(r_q100_8)
                + 21'(r_q100_8[4:2]) + 21'd1 - 21'(w_leap9[0]);

    // Stage ten: step down to the last year that starts on or before the day.
    logic [20:0] w_f1, w_f2, w_f3, w_fsel;
    logic [1:0]  w_step;
    logic [11:0] n_year10, r_year10;
    logic [8:0]  n_doy10, r_doy10;
    logic        n_leapy10, r_leapy10;
    logic [5:0]  r_min10, r_sec10;
    logic [4:0]  r_hour10;
    logic [2:0]  r_wd10;

    assign w_f1 = r_f9 - 21'(C_DAYS_PER_YEAR) - 21'(r_leap9[1]);
    assign w_f2 = r_f9 - 21'(2 * C_DAYS_PER_YEAR) - 21'(r_leap9[1]) - 21'(r_leap9[2]);
    assign w_f3 = r_f9 - 21'(3 * C_DAYS_PER_YEAR) - 21'(r_leap9[1]) - 21'(r_leap9[2])
                - 21'(r_leap9[3]);

    always_comb begin
        if (r_d9 >= r_f9) begin
            w_step = 2'd0;
            w_fsel = r_f9;
        end else if (r_d9 >= w_f1) begin
            w_step = 2'd1;
            w_fsel = w_f1;
        end else if (r_d9 >= w_f2) begin
            w_step = 2'd2;
            w_fsel = w_f2;
        end else begin
            w_step = 2'd3;
            w_fsel = w_f3;
        end
    end

    assign n_year10  = r_y9 - 12'(w_step);
    assign n_doy10   = 9'(r_d9 - w_fsel);
    assign n_leapy10 = r_leap9[w_step];

    // Stage eleven: binary split over the month start table.
    logic [3:0] w_mon_a, w_mon_b, w_mon_c;
    logic [4:0] n_mday11;
    t_civil     r_out;

    always_comb begin
        w_mon_a = (r_doy10 >= f_month_start(r_leapy10, 4'd6)) ? 4'd6 : 4'd0;
        w_mon_b = (r_doy10 >= f_month_start(r_leapy10, w_mon_a + 4'd3))
                ? w_mon_a + 4'd3 : w_mon_a;
        if (r_doy10 >= f_month_start(r_leapy10, w_mon_b + 4'd2)) begin
            w_mon_c = w_mon_b + 4'd2;
        end else if (r_doy10 >= f_month_start(r_leapy10, w_mon_b + 4'd1)) begin
            w_mon_c = w_mon_b + 4'd1;
        end else begin
            w_mon_c = w_mon_b;
        end
    end

    assign n_mday11 = 5'(r_doy10 - f_month_start(r_leapy10, w_mon_c) + 9'd1);

    // Valid bits travel down the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else begin
            r_v5  <= i_split.valid;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge i_clk) begin
        r_d5      <= n_d5;
        r_wx5     <= n_wx5;
        r_sec5    <= i_split.sec_of_day;
        r_hprod5  <= n_hprod5;
        r_yprod5  <= n_yprod5;
        r_wprod5  <= n_wprod5;

        r_hour6   <= w_hour6;
        r_rem6    <= n_rem6;
        r_y6      <= w_y6;
        r_wd6     <= n_wd6;
        r_d6      <= r_d5;

        r_mprod7  <= n_mprod7;
        r_qprod7  <= n_qprod7;
        r_rem7    <= r_rem6;
        r_y7      <= r_y6;
        r_hour7   <= r_hour6;
        r_wd7     <= r_wd6;
        r_d7      <= r_d6;

        r_min8    <= w_min8;
        r_sec8    <= n_sec8;
        r_q100_8  <= w_q100_8;
        r_r100_8  <= n_r100_8;
        r_y8      <= r_y7;
        r_hour8   <= r_hour7;
        r_wd8     <= r_wd7;
        r_d8      <= r_d7;

        r_leap9   <= w_leap9;
        r_f9      <= n_f9;
        r_y9      <= r_y8;
        r_d9      <= r_d8;
        r_min9    <= r_min8;
        r_sec9    <= r_sec8;
        r_hour9   <= r_hour8;
        r_wd9     <= r_wd8;

        r_year10  <= n_year10;
        r_doy10   <= n_doy10;
        r_leapy10 <= n_leapy10;
        r_min10   <= r_min9;
        r_sec10   <= r_sec9;
        r_hour10  <= r_hour9;
        r_wd10    <= r_wd9;

        r_out.valid   <= r_v10;
        r_out.second  <= r_sec10;
        r_out.minute  <= r_min10;
        r_out.hour    <= r_hour10;
        r_out.mday    <= n_mday11;
        r_out.month   <= w_mon_c;
        r_out.year    <= r_year10;
        r_out.weekday <= r_wd10;
    end

    always_comb begin
        o_civil       = r_out;
        o_civil.valid = r_v11;
    end

    // The time of day split never leaves the hour.
    a_hour_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 |-> (r_rem6 < C_SECS_PER_HOUR && r_hour6 < 5'd24))
        else $error("time of day split out of range");

    // The year estimate is never more than three years too high.
    a_year_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v9 |-> (w_f3 <= r_d9))
        else $error("year search ran past three steps");

    // The day of year fits the chosen year.
    a_doy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v10 |-> (r_doy10 < C_DAYS_PER_YEAR || (r_leapy10 && r_doy10 == C_DAYS_PER_YEAR)))
        else $error("day of year beyond the end of the year");

endmodule

`default_nettype wire

@@ design/epoch_seconds_to_civil_date.sv @@
// Top level: epoch seconds to Gregorian UTC date and time, fully pipelined.
// Depends on ecd_pkg, ecd_day_split and ecd_fields.
`default_nettype none

// Usage
// A word is taken at a rising clock edge at which start is high and busy is
// low. busy is never raised: the pipeline takes a new word on every cycle,
// so one word per clock is the sustained throughput.
// i_epoch_seconds is a signed count of seconds since 1970-01-01 00:00 UTC.
// The result word is on the o_ ports for exactly one cycle, marked by
// o_valid; it is taken at the edge that ends that cycle. A word passes
// through twelve register stages: an input register, three stages of day
// split (reciprocal product, remainder, correction), seven stages of
// calendar work (time of day, weekday, year estimate, year step-down,
// month split) and the output register.
// The receiver cannot hold results off and none is needed: the pipeline
// never backs up. A synchronous reset (i_rst_n low) clears every valid bit,
// so words in flight are dropped and no result follows until new words
// are taken.
module epoch_seconds_to_civil_date
    import ecd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [35:0] i_epoch_seconds,
    output logic                    o_valid,
    output logic [5:0]              o_second,
    output logic [5:0]              o_minute,
    output logic [4:0]              o_hour,
    output logic [4:0]              o_day_of_month,
    output logic [3:0]              o_month,
    output logic signed [11:0]      o_year_since_1900,
    output logic [2:0]              o_weekday
);

    logic        r_v1;
    logic [36:0] r_secs1, n_secs1;
    t_split      w_split;
    t_civil      w_civil;
    logic        r_valid;
    logic [5:0]  r_second, r_minute;
    logic [4:0]  r_hour, r_mday;
    logic [3:0]  r_month;
    logic [11:0] r_year, n_year;
    logic [2:0]  r_weekday;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Input register: shift the second count to a non-negative value.
    assign n_secs1 = {i_epoch_seconds[35], i_epoch_seconds} + C_SECS_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_secs1 <= n_secs1;
    end

    ecd_day_split u_day_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_secs  (r_secs1),
        .o_split (w_split)
    );

    ecd_fields u_fields (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_split (w_split),
        .o_civil (w_civil)
    );

    // Output register: rebase the year on 1900.
    assign n_year = w_civil.year - C_YEAR_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_civil.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_second  <= w_civil.second;
        r_minute  <= w_civil.minute;
        r_hour    <= w_civil.hour;
        r_mday    <= w_civil.mday;
        r_month   <= w_civil.month;
        r_year    <= n_year;
        r_weekday <= w_civil.weekday;
    end

    assign o_valid           = r_valid;
    assign o_second          = r_second;
    assign o_minute          = r_minute;
    assign o_hour            = r_hour;
    assign o_day_of_month    = r_mday;
    assign o_month           = r_month;
    assign o_year_since_1900 = signed'(r_year);
    assign o_weekday         = r_weekday;

    // Every accepted word comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##12 o_valid)
        else $error("result word missing after pipeline latency");

endmodule

`default_nettype wire
